// File: sv/rau_pkg.sv
// Shared types and codes of the rational arithmetic unit.
`default_nettype none
package rau_pkg;

  localparam int FIELD_W = 32;   // port width of numerators and denominators
  localparam int DEN_W   = 31;   // port width of the result denominator

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_CMP = 3'd4;

  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // what the back end has to do with a queued word
  typedef enum logic [1:0] {
    K_NONE,   // unused mode: all-zero result
    K_ZDEN,   // zero denominator: flag only
    K_CALC    // full arithmetic or compare
  } kind_t;

  typedef struct packed {
    logic [2:0]         mode;
    kind_t              kind;
    logic               a_neg;   // sign of lhs, denominator sign folded in
    logic               c_neg;   // sign of rhs, denominator sign folded in
    logic [FIELD_W-1:0] a_mag;
    logic [FIELD_W-1:0] b_mag;
    logic [FIELD_W-1:0] c_mag;
    logic [FIELD_W-1:0] d_mag;
  } entry_t;

endpackage
`default_nettype wire

// File: sv/rau_fifo.sv
// Two-entry register queue between front and back end.
`default_nettype none
module rau_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);

  logic [DW-1:0] mem_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= wdata;
  end

  assign full  = cnt_r[1];
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

endmodule
`default_nettype wire

// File: sv/rau_front.sv
// Front end: takes operand words, folds signs and classifies them.
`default_nettype none
module rau_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_mode,
  input  logic signed [rau_pkg::FIELD_W-1:0] in_lhs_num,
  input  logic signed [rau_pkg::FIELD_W-1:0] in_lhs_den,
  input  logic signed [rau_pkg::FIELD_W-1:0] in_rhs_num,
  input  logic signed [rau_pkg::FIELD_W-1:0] in_rhs_den,
  input  logic                         q_full,
  output logic                         q_push,
  output rau_pkg::entry_t              q_entry
);
  import rau_pkg::*;

  localparam int W = VALUE_WIDTH;

  logic [W-1:0] a_v, b_v, c_v, d_v;
  logic [W-1:0] a_m, b_m, c_m, d_m;
  logic         zden;

  // magnitude of the low W bits, two's complement
  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    a_v = in_lhs_num[W-1:0];
    b_v = in_lhs_den[W-1:0];
    c_v = in_rhs_num[W-1:0];
    d_v = in_rhs_den[W-1:0];
    a_m = mag_of(a_v);
    b_m = mag_of(b_v);
    c_m = mag_of(c_v);
    d_m = mag_of(d_v);
    zden = (b_m == '0) || (d_m == '0) || ((in_mode == MODE_DIV) && (c_m == '0));

    q_entry.mode  = in_mode;
    q_entry.a_neg = (a_v[W-1] ^ b_v[W-1]) && (a_m != '0);
    q_entry.c_neg = (c_v[W-1] ^ d_v[W-1]) && (c_m != '0);
    q_entry.a_mag = FIELD_W'(a_m);
    q_entry.b_mag = FIELD_W'(b_m);
    q_entry.c_mag = FIELD_W'(c_m);
    q_entry.d_mag = FIELD_W'(d_m);
    if (in_mode > MODE_CMP) q_entry.kind = K_NONE;
    else if (zden)          q_entry.kind = K_ZDEN;
    else                    q_entry.kind = K_CALC;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule
`default_nettype wire

// File: sv/rau_back.sv
// Back end: products, signed sum, binary gcd, reduction and result register.
`default_nettype none
module rau_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  rau_pkg::entry_t                    q_entry,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rau_pkg::FIELD_W-1:0] out_result_num,
  output logic [rau_pkg::DEN_W-1:0]          out_result_den,
  output logic [1:0]                         out_order,
  output logic [1:0]                         out_status
);
  import rau_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int PW = 2 * W;
  localparam int KW = $clog2(PW + 1);
  localparam logic [PW-1:0] LIM = PW'(1) << (W - 1);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_GCD, S_DIV, S_OUT} state_t;

  state_t        state_r, state_nxt;
  entry_t        ent_r, ent_nxt;
  logic [1:0]    step_r, step_nxt;
  logic [PW-1:0] p0_r, p0_nxt, p1_r, p1_nxt;
  logic [PW-1:0] den_r, den_nxt, nmag_r, nmag_nxt;
  logic          nneg_r, nneg_nxt;
  logic [1:0]    ord_r, ord_nxt;
  logic [PW-1:0] x_r, x_nxt, y_r, y_nxt, g_r, g_nxt;
  logic [KW-1:0] k_r, k_nxt, cnt_r, cnt_nxt;
  logic [PW:0]   remn_r, remn_nxt, remd_r, remd_nxt;
  logic          ov_r, ov_nxt;
  logic signed [FIELD_W-1:0] onum_r, onum_nxt;
  logic [DEN_W-1:0] oden_r, oden_nxt;
  logic [1:0]    oord_r, oord_nxt, ost_r, ost_nxt;

  logic          out_free;
  logic [W-1:0]  ma, mb;
  logic [PW-1:0] prod;
  logic          s0, s1, ge_n, ge_d;
  logic [PW:0]   rn, rd;
  logic [PW-1:0] qmag;

  assign out_free = !ov_r || !out_stall;

  // one shared multiplier, operands picked by step and mode
  always_comb begin
    unique case (step_r)
      2'd0: begin
        ma = ent_r.a_mag[W-1:0];
        mb = (ent_r.mode == MODE_MUL) ? ent_r.c_mag[W-1:0] : ent_r.d_mag[W-1:0];
      end
      2'd1: begin
        ma = ent_r.c_mag[W-1:0];
        mb = ent_r.b_mag[W-1:0];
      end
      default: begin
        ma = ent_r.b_mag[W-1:0];
        mb = (ent_r.mode == MODE_DIV) ? ent_r.c_mag[W-1:0] : ent_r.d_mag[W-1:0];
      end
    endcase
    prod = PW'(ma) * PW'(mb);
  end

  always_comb begin
    state_nxt = state_r;  ent_nxt  = ent_r;   step_nxt = step_r;
    p0_nxt    = p0_r;     p1_nxt   = p1_r;    den_nxt  = den_r;
    nmag_nxt  = nmag_r;   nneg_nxt = nneg_r;  ord_nxt  = ord_r;
    x_nxt     = x_r;      y_nxt    = y_r;     g_nxt    = g_r;
    k_nxt     = k_r;      cnt_nxt  = cnt_r;
    remn_nxt  = remn_r;   remd_nxt = remd_r;
    onum_nxt  = onum_r;   oden_nxt = oden_r;  oord_nxt = oord_r;  ost_nxt = ost_r;
    ov_nxt    = ov_r && out_stall;
    q_pop     = 1'b0;
    s0   = 1'b0;  s1 = 1'b0;
    rn   = '0;    rd = '0;  ge_n = 1'b0;  ge_d = 1'b0;
    qmag = nmag_r;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty && (q_entry.kind == K_CALC || out_free)) begin
          q_pop   = 1'b1;
          ent_nxt = q_entry;
          if (q_entry.kind == K_CALC) begin
            step_nxt  = 2'd0;
            state_nxt = S_MUL;
          end else begin
            ov_nxt   = 1'b1;
            onum_nxt = '0;
            oden_nxt = '0;
            oord_nxt = ORD_LESS;
            ost_nxt  = (q_entry.kind == K_ZDEN) ? ST_ZDEN : ST_OK;
          end
        end
      end
      S_MUL: begin
        unique case (step_r)
          2'd0:    p0_nxt  = prod;
          2'd1:    p1_nxt  = prod;
          default: den_nxt = prod;
        endcase
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd2) state_nxt = S_SUM;
      end
      S_SUM: begin
        s0 = ((ent_r.mode == MODE_MUL || ent_r.mode == MODE_DIV) ?
              (ent_r.a_neg ^ ent_r.c_neg) : ent_r.a_neg) && (p0_r != '0);
        s1 = (ent_r.c_neg ^ (ent_r.mode == MODE_SUB)) && (p1_r != '0);
        if (s0 != s1)         ord_nxt = s0 ? ORD_LESS : ORD_GREATER;
        else if (p0_r == p1_r) ord_nxt = ORD_EQUAL;
        else if (s0)          ord_nxt = (p0_r > p1_r) ? ORD_LESS : ORD_GREATER;
        else                  ord_nxt = (p0_r > p1_r) ? ORD_GREATER : ORD_LESS;
        if (ent_r.mode == MODE_MUL || ent_r.mode == MODE_DIV) begin
          nmag_nxt = p0_r;
          nneg_nxt = s0;
        end else if (s0 == s1) begin
          nmag_nxt = p0_r + p1_r;
          nneg_nxt = s0;
        end else if (p0_r >= p1_r) begin
          nmag_nxt = p0_r - p1_r;
          nneg_nxt = s0;
        end else begin
          nmag_nxt = p1_r - p0_r;
          nneg_nxt = s1;
        end
        x_nxt = nmag_nxt;
        y_nxt = den_r;
        k_nxt = '0;
        if (ent_r.mode == MODE_CMP || nmag_nxt == '0) state_nxt = S_OUT;
        else                                         state_nxt = S_GCD;
      end
      S_GCD: begin
        // Stein's algorithm, one step a cycle
        if (x_r == '0) begin
          g_nxt     = y_r << k_r;
          remn_nxt  = '0;
          remd_nxt  = '0;
          cnt_nxt   = KW'(PW);
          state_nxt = S_DIV;
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_r >= y_r) begin
          x_nxt = x_r - y_r;
        end else begin
          y_nxt = y_r - x_r;
        end
      end
      S_DIV: begin
        // both quotients by g, one restoring step a cycle, shifted in place
        rn   = {remn_r[PW-1:0], nmag_r[PW-1]};
        rd   = {remd_r[PW-1:0], den_r[PW-1]};
        ge_n = rn >= {1'b0, g_r};
        ge_d = rd >= {1'b0, g_r};
        remn_nxt = ge_n ? (rn - {1'b0, g_r}) : rn;
        remd_nxt = ge_d ? (rd - {1'b0, g_r}) : rd;
        nmag_nxt = {nmag_r[PW-2:0], ge_n};
        den_nxt  = {den_r[PW-2:0], ge_d};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == KW'(1)) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
          onum_nxt  = '0;
          oden_nxt  = '0;
          oord_nxt  = ORD_LESS;
          ost_nxt   = ST_OK;
          if (ent_r.mode == MODE_CMP) begin
            oord_nxt = ord_r;
          end else if (nmag_r == '0) begin
            oden_nxt = DEN_W'(1);
          end else if (den_r >= LIM || (nneg_r ? nmag_r > LIM : nmag_r >= LIM)) begin
            ost_nxt = ST_OVF;
          end else begin
            qmag     = nneg_r ? (~nmag_r + 1'b1) : nmag_r;
            onum_nxt = FIELD_W'(signed'(qmag[W-1:0]));
            oden_nxt = DEN_W'(den_r[W-2:0]);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    ent_r  <= ent_nxt;   step_r <= step_nxt;
    p0_r   <= p0_nxt;    p1_r   <= p1_nxt;    den_r  <= den_nxt;
    nmag_r <= nmag_nxt;  nneg_r <= nneg_nxt;  ord_r  <= ord_nxt;
    x_r    <= x_nxt;     y_r    <= y_nxt;     g_r    <= g_nxt;
    k_r    <= k_nxt;     cnt_r  <= cnt_nxt;
    remn_r <= remn_nxt;  remd_r <= remd_nxt;
    onum_r <= onum_nxt;  oden_r <= oden_nxt;  oord_r <= oord_nxt;  ost_r <= ost_nxt;
  end

  assign out_valid      = ov_r;
  assign out_result_num = onum_r;
  assign out_result_den = oden_r;
  assign out_order      = oord_r;
  assign out_status     = ost_r;

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GCD |-> y_r != '0) else $error("gcd operand reached zero");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> g_r != '0) else $error("reduction by zero divisor");

  a_flag_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ost_r != ST_OK |-> onum_r == '0 && oden_r == '0)
    else $error("flagged word carries a value");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r != S_IDLE || ov_r) else $error("popped word went nowhere");

endmodule
`default_nettype wire

// File: sv/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
//
// Usage: an input word carries a mode (add, subtract, multiply, divide,
// compare) and two fractions lhs_num/lhs_den and rhs_num/rhs_den; the low
// VALUE_WIDTH bits of each are taken as two's complement. Each word gives one
// result word: a reduced fraction with a positive denominator (0/1 for zero),
// an order code for compare, and a status (ok, zero denominator, overflow).
// Channels use valid/stall; a word moves when valid is high and stall low.
// The front end folds signs and classifies, then writes a two-entry queue;
// in_stall is high only while the queue is full.
// The back end takes a word from the queue, forms three products on the shared
// multiplier, then the signed sum, then the binary gcd (one step per cycle) and
// restoring division, then writes the result register. Compare and a zero result
// skip the gcd and division; unused modes and zero denominators go from the
// queue straight to the result register. The back end works on one word at a
// time; its gcd and divider loops set the throughput.
// Reset empties the queue and the result register. While out_stall is high
// the result word holds and no new result is written; the queue keeps filling.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         in_mode,
  input  logic signed [rau_pkg::FIELD_W-1:0] in_lhs_num,
  input  logic signed [rau_pkg::FIELD_W-1:0] in_lhs_den,
  input  logic signed [rau_pkg::FIELD_W-1:0] in_rhs_num,
  input  logic signed [rau_pkg::FIELD_W-1:0] in_rhs_den,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rau_pkg::FIELD_W-1:0] out_result_num,
  output logic [rau_pkg::DEN_W-1:0]          out_result_den,
  output logic [1:0]                         out_order,
  output logic [1:0]                         out_status
);
  import rau_pkg::*;

  localparam int EW = $bits(entry_t);

  entry_t        push_ent, pop_ent;
  logic [EW-1:0] pop_bits;
  logic          q_push, q_pop, q_full, q_empty;

  rau_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_lhs_num (in_lhs_num),
    .in_lhs_den (in_lhs_den),
    .in_rhs_num (in_rhs_num),
    .in_rhs_den (in_rhs_den),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (push_ent)
  );

  // decouples classification from the long gcd work
  rau_fifo #(.DW(EW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_ent),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (pop_bits),
    .empty (q_empty)
  );

  assign pop_ent = entry_t'(pop_bits);

  rau_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_entry        (pop_ent),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_num (out_result_num),
    .out_result_den (out_result_den),
    .out_order      (out_order),
    .out_status     (out_status)
  );

endmodule
`default_nettype wire

// File: sim/tb_rational_arithmetic_unit.sv
// Testbench of the rational arithmetic unit: directed and random fractions, checked
// against a behavioural predictor of the reduced result.
`timescale 1ns / 100ps
`default_nettype none
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int VW = 32;
  localparam int STALL_LIMIT = 20000;   // cycles with no word moving
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic [1:0]         order;
    logic [1:0]         status;
  } fraction_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_mode = '0;
  logic signed [31:0] in_lhs_num = '0, in_lhs_den = '0, in_rhs_num = '0, in_rhs_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_result_num;
  logic [30:0] out_result_den;
  logic [1:0] out_order, out_status;

  fraction_res_t pending_results[$];
  int errors = 0;
  int idle_pct = 26;   // chance of a gap, per cent; zero for a clean stretch
  int quiet_cycles = 0;

  rational_arithmetic_unit #(.VALUE_WIDTH(VW)) dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // signed magnitude at up to 128 bits; products of two 32-bit magnitudes fit easily
  typedef struct {
    bit         neg;
    bit [127:0] mag;
  } smag_t;

  function automatic smag_t split_operand(logic [31:0] raw);
    smag_t r;
    r.neg = raw[31];
    r.mag = raw[31] ? 128'(-{1'b1, raw}) & 128'hFFFFFFFF_FFFFFFFF : 128'(raw);
    if (raw[31]) r.mag = 128'(33'h1_0000_0000 - {1'b0, raw});
    return r;
  endfunction

  function automatic smag_t times(smag_t a, smag_t b);
    smag_t r;
    r.mag = a.mag * b.mag;
    r.neg = (r.mag != 0) && (a.neg != b.neg);
    return r;
  endfunction

  function automatic smag_t plus(smag_t a, smag_t b);
    smag_t r;
    if (a.neg == b.neg) begin
      r.mag = a.mag + b.mag; r.neg = a.neg;
    end else if (a.mag >= b.mag) begin
      r.mag = a.mag - b.mag; r.neg = a.neg;
    end else begin
      r.mag = b.mag - a.mag; r.neg = b.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic bit [127:0] common_divisor(bit [127:0] x, bit [127:0] y);
    bit [127:0] t;
    while (y != 0) begin
      t = x % y; x = y; y = t;
    end
    return x;
  endfunction

  function automatic fraction_res_t predict_fraction(logic [2:0] mode, logic [31:0] ln,
      logic [31:0] ld, logic [31:0] rn, logic [31:0] rd);
    fraction_res_t res;
    smag_t a, b, c, d, n, t, p, q;
    bit [127:0] den, g, lim;
    res = '{num: '0, den: '0, order: ORD_LESS, status: ST_OK};
    a = split_operand(ln); b = split_operand(ld);
    c = split_operand(rn); d = split_operand(rd);
    if (mode > MODE_CMP) return res;
    if (b.mag == 0 || d.mag == 0 || (mode == MODE_DIV && c.mag == 0)) begin
      res.status = ST_ZDEN;
      return res;
    end
    if (b.neg) begin a.neg = !a.neg; b.neg = 1'b0; end
    if (d.neg) begin c.neg = !c.neg; d.neg = 1'b0; end
    if (a.mag == 0) a.neg = 1'b0;
    if (c.mag == 0) c.neg = 1'b0;
    if (mode == MODE_CMP) begin
      p = times(a, d); q = times(c, b);
      if (p.neg != q.neg) res.order = p.neg ? ORD_LESS : ORD_GREATER;
      else if (p.mag == q.mag) res.order = ORD_EQUAL;
      else if (p.neg) res.order = (p.mag > q.mag) ? ORD_LESS : ORD_GREATER;
      else res.order = (p.mag > q.mag) ? ORD_GREATER : ORD_LESS;
      return res;
    end
    case (mode)
      MODE_ADD: begin n = plus(times(a, d), times(c, b)); den = b.mag * d.mag; end
      MODE_SUB: begin
        t = times(c, b);
        if (t.mag != 0) t.neg = !t.neg;
        n = plus(times(a, d), t); den = b.mag * d.mag;
      end
      MODE_MUL: begin n = times(a, c); den = b.mag * d.mag; end
      default: begin
        n = times(a, d); den = b.mag * c.mag;
        if (c.neg && n.mag != 0) n.neg = !n.neg;
      end
    endcase
    g = common_divisor(n.mag, den);
    n.mag = n.mag / g; den = den / g;
    if (n.mag == 0) begin n.neg = 1'b0; den = 1; end
    lim = 128'd1 << (VW - 1);
    if (den > lim - 1 || (n.neg ? n.mag > lim : n.mag > lim - 1)) begin
      res.status = ST_OVF;
      return res;
    end
    res.num = n.neg ? -n.mag[31:0] : n.mag[31:0];
    res.den = den[30:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  // one word in: optional gap, then hold until accepted; valid stays up afterwards
  task automatic send_fraction(logic [2:0] mode, logic [31:0] ln, logic [31:0] ld,
      logic [31:0] rn, logic [31:0] rd);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; in_mode <= mode;
    in_lhs_num <= ln; in_lhs_den <= ld; in_rhs_num <= rn; in_rhs_den <= rd;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_fraction(mode, ln, ld, rn, rd));
    @(negedge clk);
  endtask

  // result stall: random, held off while idle_pct is zero
  always @(negedge clk)
    out_stall <= rst_n && ($urandom_range(99) < idle_pct);

  always @(posedge clk) begin
    fraction_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_result_num !== want.num) report_mismatch("num", out_result_num, want.num);
        if (out_result_den !== want.den) report_mismatch("den", out_result_den, want.den);
        if (out_order !== want.order) report_mismatch("order", out_order, want.order);
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // sender idles until every expected result is back
  task automatic wait_drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // corner values of a field, else a random value
  function automatic logic [31:0] corner_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'h1;
      4: return 32'hFFFF_FFFF;
      5: return 32'h8000_0001;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    logic [2:0] m;
    for (int i = 0; i <= MODE_CMP; i++) begin
      m = i[2:0];
      send_fraction(m, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
      send_fraction(m, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    end
    send_fraction(MODE_ADD, 32'sd3, 32'sd0, 32'sd1, 32'sd1);       // zero lhs denominator
    send_fraction(MODE_DIV, 32'sd3, 32'sd1, 32'sd0, 32'sd1);       // divide by zero
    send_fraction(MODE_SUB, 32'sd5, -32'sd7, -32'sd5, 32'sd7);     // zero result
    send_fraction(MODE_MUL, 32'h7FFF_FFFF, 32'sd1, 32'sd2, 32'sd1); // overflow
    send_fraction(MODE_CMP, 32'sd2, 32'sd4, -32'sd1, -32'sd2);     // equal
    send_fraction(3'd5, 32'sd1, 32'sd1, 32'sd1, 32'sd1);           // unused modes
    send_fraction(3'd7, 32'hFFFF_FFFF, 32'sd0, 32'sd1, 32'sd1);
    send_fraction(MODE_MUL, 32'h8000_0000, 32'sd1, 32'hFFFF_FFFF, 32'sd1);
  endtask

  task automatic test_random(int count);
    logic [2:0] m;
    for (int i = 0; i < count; i++) begin
      m = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
      case ($urandom_range(3))
        0: send_fraction(m, corner_value(), corner_value(), corner_value(), corner_value());
        1: send_fraction(m, $urandom, $urandom, $urandom, $urandom);
        default: send_fraction(m, 32'($signed(16'($urandom))), 32'($signed(10'($urandom))),
                   32'($signed(16'($urandom))), 32'($signed(10'($urandom))));
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(500);
    wait_drain();              // sender holds off until all results are back
    idle_pct = 0;
    test_random(300);          // back-to-back stretch
    idle_pct = 26;
    test_random(780);
    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
